@@ hdl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared constants, command and status codes, state encoding and payload types.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned PosW      = 5;

  typedef enum logic [2:0] {
    CmdInsFront = 3'd0,
    CmdInsBack  = 3'd1,
    CmdInsPos   = 3'd2,
    CmdDelFront = 3'd3,
    CmdDelBack  = 3'd4,
    CmdDelPos   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    StDone   = 2'd0,
    StBadPos = 2'd1,
    StFull   = 2'd2,
    StEmpty  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SShiftRd,
    SShiftWr,
    SFinish,
    SRespond
  } state_e;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [DataWidth-1:0] value;
    logic [PosW-1:0]      position;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [CntW-1:0] entry_count;
  } ple_out_t;

endpackage

@@ hdl/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list with insert and delete at front, back or position.
// ----------------------------------------------------------------------------
// Commands arrive as transactions on the in_valid_i/in_ready_o channel and
// each produces exactly one result transaction on out_valid_o/out_ready_i
// holding a status and the entry count after the command.
// The list lives in a single-port-write, single-port-read memory. Entries
// after the point of change are moved one at a time by a shared read/write
// step: each moved entry takes a read state (SShiftRd) and a write state
// (SShiftWr). A rejected command goes from idle straight to the respond
// state, which loads its result. An accepted command first moves its M
// entries (M is at most Depth-1), then passes the finish state, which
// writes an inserted value and updates the count, and then the respond
// state. The engine accepts no new command until the current one has
// placed its result in the output register.
// Reset clears the entry count and empties the output register; the
// memory contents are not cleared, since only slots below the count are used.
// If the receiver stalls, the result waits in the output register and a
// finished command holds the engine until that register is free.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  ple_in_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output ple_out_t out_data_o
);

  logic [DataWidth-1:0] mem [Depth];

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 ins_q, ins_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [IdxW-1:0]      ptr_q, ptr_d;
  logic [DataWidth-1:0] val_q, val_d;
  status_e              status_q, status_d;
  logic [DataWidth-1:0] rd_data_q;
  logic                 out_valid_q, out_valid_d;
  ple_out_t             out_data_q, out_data_d;

  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [DataWidth-1:0] mem_wdata;
  logic [IdxW-1:0]      mem_raddr;

  logic [IdxW-1:0]      step_addr;
  logic [CntW-1:0]      count_p1;
  logic [IdxW-1:0]      pos_m1;
  logic [IdxW-1:0]      cnt_m1;

  assign count_p1  = count_q + CntW'(1);
  assign pos_m1    = IdxW'(in_data_i.position - PosW'(1));
  assign cnt_m1    = IdxW'(count_q - CntW'(1));
  assign step_addr = ins_q ? (ptr_q - IdxW'(1)) : (ptr_q + IdxW'(1));
  assign mem_raddr = step_addr;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ins_d       = ins_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    val_d       = val_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = rd_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          val_d    = in_data_i.value;
          status_d = StDone;
          ins_d    = 1'b0;
          idx_d    = '0;
          case (cmd_e'(in_data_i.cmd))
            CmdInsFront, CmdInsBack, CmdInsPos: begin
              ins_d = 1'b1;
              if (count_q == CntW'(Depth)) begin
                status_d = StFull;
              end else if (in_data_i.cmd == CmdInsFront) begin
                idx_d = '0;
              end else if (in_data_i.cmd == CmdInsBack) begin
                idx_d = IdxW'(count_q);
              end else if (in_data_i.position == '0 ||
                           {1'b0, in_data_i.position} > {1'b0, count_p1}) begin
                status_d = StBadPos;
              end else begin
                idx_d = pos_m1;
              end
            end
            CmdDelFront, CmdDelBack, CmdDelPos: begin
              if (count_q == '0) begin
                status_d = StEmpty;
              end else if (in_data_i.cmd == CmdDelFront) begin
                idx_d = '0;
              end else if (in_data_i.cmd == CmdDelBack) begin
                idx_d = cnt_m1;
              end else if (in_data_i.position == '0 ||
                           {1'b0, in_data_i.position} > {1'b0, count_q}) begin
                status_d = StBadPos;
              end else begin
                idx_d = pos_m1;
              end
            end
            default: begin
              status_d = StBadPos;
            end
          endcase

          ptr_d = ins_d ? IdxW'(count_q) : idx_d;
          if (status_d != StDone) begin
            state_d = SRespond;
          end else if (ins_d ? (count_q > CntW'(idx_d))
                             : ((CntW'(idx_d) + CntW'(1)) < count_q)) begin
            state_d = SShiftRd;
          end else begin
            state_d = SFinish;
          end
        end
      end
      SShiftRd: begin
        state_d = SShiftWr;
      end
      SShiftWr: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = rd_data_q;
        ptr_d     = step_addr;
        if (ins_q ? (step_addr > idx_q)
                  : ((CntW'(step_addr) + CntW'(1)) < count_q)) begin
          state_d = SShiftRd;
        end else begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        if (ins_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = val_q;
          count_d   = count_q + CntW'(1);
        end else begin
          count_d   = count_q - CntW'(1);
        end
        state_d = SRespond;
      end
      SRespond: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = status_q;
          out_data_d.entry_count = count_q;
          state_d                = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q      <= ins_d;
    idx_q      <= idx_d;
    ptr_q      <= ptr_d;
    val_q      <= val_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Entry count exceeds the list depth.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q) == SFinish &&
      (count_q == $past(count_q) + CntW'(1) || count_q == $past(count_q) - CntW'(1)))
    else $error("Entry count changed outside the finish step or by more than one.");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == SRespond)
    else $error("A result appeared without passing through the respond step.");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SShiftWr && ins_q) |-> ptr_q > idx_q)
    else $error("Insert shift wrote at or below the insertion slot.");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRespond && out_valid_q && !out_ready_i) |=> state_q == SRespond)
    else $error("Respond step left while the output register was occupied.");

endmodule

@@ test/positional_list_engine_tb.sv @@
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Sends list commands on the input channel and checks the status and entry
// count of every result against a queue-based model of the list. The run
// covers empty and full lists, rejected positions, spare command codes and
// a long random walk of the list size under varied sender and receiver
// idling.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  import ple_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam int unsigned MaxReported = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ple_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ple_out_t out_data_o;

  logic [DataWidth-1:0] list_entries[$];
  ple_out_t             expected_results[$];
  int unsigned          mismatch_count = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;

  positional_list_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic ple_out_t predict_list_command(input ple_in_t item);
    status_e     st;
    int unsigned n;
    ple_out_t    res;
    st = StDone;
    n = list_entries.size();
    case (item.cmd)
      CmdInsFront, CmdInsBack, CmdInsPos: begin
        if (n >= Depth) begin
          st = StFull;
        end else if (item.cmd == CmdInsFront) begin
          list_entries.push_front(item.value);
        end else if (item.cmd == CmdInsBack) begin
          list_entries.push_back(item.value);
        end else if (item.position < 1 || item.position > n + 1) begin
          st = StBadPos;
        end else begin
          list_entries.insert(item.position - 1, item.value);
        end
      end
      CmdDelFront, CmdDelBack, CmdDelPos: begin
        if (n == 0) begin
          st = StEmpty;
        end else if (item.cmd == CmdDelFront) begin
          list_entries.delete(0);
        end else if (item.cmd == CmdDelBack) begin
          list_entries.delete(n - 1);
        end else if (item.position < 1 || item.position > n) begin
          st = StBadPos;
        end else begin
          list_entries.delete(item.position - 1);
        end
      end
      default: st = StBadPos;
    endcase
    res.status = st;
    res.entry_count = CntW'(list_entries.size());
    return res;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk_i) begin
    ple_out_t want;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result status=%0d count=%0d",
                                out_data_o.status, out_data_o.entry_count));
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status ||
            out_data_o.entry_count !== want.entry_count) begin
          note_mismatch($sformatf("status exp=%0d act=%0d, count exp=%0d act=%0d",
                                  want.status, out_data_o.status,
                                  want.entry_count, out_data_o.entry_count));
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_results.push_back(predict_list_command(in_data_i));
    end
  end

  // Valid stays high across back-to-back transactions and is lowered only
  // when an idle gap is taken before the next one.
  task automatic send_cmd(input logic [2:0] cmd, input logic [DataWidth-1:0] value,
                          input logic [PosW-1:0] position);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{cmd: cmd, value: value, position: position};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (2 * Depth + 8) @(posedge clk_i);
  endtask

  task automatic test_corner_cases();
    send_cmd(CmdDelFront, '0, '0);
    send_cmd(CmdDelBack, '1, '1);
    send_cmd(CmdDelPos, '0, 5'd1);
    send_cmd(CmdSpare6, '1, '1);
    send_cmd(CmdSpare7, '0, '0);
    send_cmd(CmdInsPos, 32'h1234_5678, 5'd0);
    send_cmd(CmdInsPos, 32'h1234_5678, 5'd2);
    send_cmd(CmdInsPos, '0, 5'd1);
    send_cmd(CmdInsFront, '1, '1);
    send_cmd(CmdInsBack, '0, '0);
    send_cmd(CmdInsPos, 32'hA5A5_A5A5, 5'd4);
    send_cmd(CmdInsPos, 32'h5A5A_5A5A, 5'd31);
    send_cmd(CmdDelPos, '0, 5'd0);
    send_cmd(CmdDelPos, '0, 5'd5);
    send_cmd(CmdDelPos, '0, 5'd4);
    send_cmd(CmdDelPos, '1, 5'd2);
    send_cmd(CmdDelBack, '0, '0);
    send_cmd(CmdDelFront, '0, '0);
    send_cmd(CmdDelPos, '0, 5'd31);
  endtask

  // Fills the list to capacity, checks that the full and empty checks win
  // over the position check, and drains it again.
  task automatic test_capacity();
    int unsigned n;
    wait_drained();
    n = list_entries.size();
    while (n < Depth) begin
      case (n % 3)
        0: send_cmd(CmdInsFront, $urandom, '0);
        1: send_cmd(CmdInsBack, $urandom, '1);
        default: send_cmd(CmdInsPos, $urandom, PosW'($urandom_range(n + 1, 1)));
      endcase
      n++;
    end
    send_cmd(CmdInsFront, '1, '0);
    send_cmd(CmdInsBack, '0, '1);
    send_cmd(CmdInsPos, '1, 5'd0);
    send_cmd(CmdInsPos, '1, 5'd17);
    send_cmd(CmdDelPos, '0, 5'd17);
    send_cmd(CmdDelPos, '0, 5'd16);
    n--;
    while (n > 0) begin
      case (n % 3)
        0: send_cmd(CmdDelFront, '0, '0);
        1: send_cmd(CmdDelBack, '0, '0);
        default: send_cmd(CmdDelPos, '0, PosW'($urandom_range(n, 1)));
      endcase
      n--;
    end
    send_cmd(CmdDelPos, '0, 5'd0);
    send_cmd(CmdDelBack, '1, '1);
  endtask

  // Random commands with an insert bias that steers the list size; the
  // positions are mostly legal for the size seen when the command is built.
  task automatic test_random_walk(input int unsigned n_items, input int unsigned insert_pct);
    logic [2:0]           cmd;
    logic [DataWidth-1:0] value;
    logic [PosW-1:0]      position;
    int unsigned          r;
    int unsigned          n;
    repeat (n_items) begin
      n = list_entries.size();
      r = $urandom_range(99);
      if (r < 2) begin
        cmd = r[0] ? CmdSpare7 : CmdSpare6;
      end else if (r < insert_pct) begin
        cmd = 3'(int'(CmdInsFront) + $urandom_range(2));
      end else begin
        cmd = 3'(int'(CmdDelFront) + $urandom_range(2));
      end
      if ($urandom_range(99) < 15) begin
        position = PosW'($urandom_range(31));
      end else if (cmd == CmdInsPos) begin
        position = PosW'($urandom_range(n + 1, 1));
      end else begin
        position = PosW'($urandom_range(n > 0 ? n : 1, 1));
      end
      case ($urandom_range(9))
        0: value = '0;
        1: value = '1;
        default: value = $urandom;
      endcase
      send_cmd(cmd, value, position);
    end
  endtask

  task automatic test_load_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    test_random_walk(125, 70);
    test_random_walk(125, 28);
    test_random_walk(125, 50);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cases();
    test_capacity();
    test_load_phase(0, 0);
    wait_drained();
    test_load_phase(62, 0);
    test_load_phase(0, 62);
    wait_drained();
    test_load_phase(38, 38);
    wait_drained();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
